@@ rtl/line_raster_generator_macros.svh @@
// assertion macros for the line raster generator
// used by line_raster_generator.sv, no other dependencies
`ifndef LINE_RASTER_GENERATOR_MACROS_SVH
`define LINE_RASTER_GENERATOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LRG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define LRG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lrg_pkg.sv @@
// shared types and constants for the line raster generator
// no dependencies
`timescale 1ns / 1ps

package lrg_pkg;

  localparam int REG_W     = 13;
  localparam int ADDR_W    = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [REG_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [REG_W-1:0] SCREEN_HEIGHT_RST = 13'd480;
  localparam logic [REG_W-1:0] ROW_PITCH_RST     = 13'd640;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_ROW_PITCH     = 2'd2
  } cfg_index_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } command_t;

endpackage

@@ rtl/lrg_if.sv @@
// valid/ready channel interfaces: command beats in, pixel beats out
// depends on lrg_pkg
`timescale 1ns / 1ps

interface lrg_in_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;

  modport source (output valid, command, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, command, x_start, y_start, x_end, y_end, output ready);
endinterface

interface lrg_out_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [lrg_pkg::ADDR_W-1:0]   pixel_address;
  logic                         visible;
  logic                         last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_address, visible, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_address, visible, last_pixel,
                  output ready);
endinterface

@@ rtl/line_raster_generator.sv @@
// line raster generator top level: bresenham stepper with a registered pixel output
// depends on lrg_pkg, lrg_if.sv and line_raster_generator_macros.svh
// one command beat per cycle; a step beat's pixel is registered at the accepting edge
// and can leave next cycle (coordinates, visibility and address multiply-add in one pass)
// load beats give no pixel; a pixel waiting on the output holds off the input
// synchronous active-low reset: no line loaded, output empty, registers at defaults
`timescale 1ns / 1ps
`include "line_raster_generator_macros.svh"

module line_raster_generator #(
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lrg_in_if.sink                        in_ch,
  lrg_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [lrg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lrg_pkg::REG_W-1:0]     cfg_data
);

  localparam int C      = COORD_BITS;
  localparam int D_W    = C + 1;
  localparam int E_W    = C + 3;
  localparam int PROD_W = C + lrg_pkg::REG_W;
  localparam int CMP_W  = (C > lrg_pkg::REG_W) ? C : lrg_pkg::REG_W;
  localparam int A_W    = lrg_pkg::ADDR_W;

  // configuration
  logic [lrg_pkg::REG_W-1:0] width_r, height_r, pitch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lrg_pkg::SCREEN_WIDTH_RST;
      height_r <= lrg_pkg::SCREEN_HEIGHT_RST;
      pitch_r  <= lrg_pkg::ROW_PITCH_RST;
    end else if (cfg_we) begin
      unique case (lrg_pkg::cfg_index_t'(cfg_index))
        lrg_pkg::CFG_SCREEN_WIDTH:  width_r  <= cfg_data;
        lrg_pkg::CFG_SCREEN_HEIGHT: height_r <= cfg_data;
        lrg_pkg::CFG_ROW_PITCH:     pitch_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // line state
  logic                  active_r, active_nxt;
  logic                  steep_r, steep_nxt;
  logic signed [C-1:0]   major_pos_r, major_pos_nxt;
  logic signed [C-1:0]   major_end_r, major_end_nxt;
  logic signed [C-1:0]   minor_pos_r, minor_pos_nxt;
  logic                  minor_dir_r, minor_dir_nxt;
  logic [D_W-1:0]        major_delta_r, major_delta_nxt;
  logic [D_W-1:0]        minor_delta_r, minor_delta_nxt;
  logic signed [E_W-1:0] error_r, error_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic signed [C-1:0]   out_x_r, out_y_r;
  logic [A_W-1:0]        out_addr_r;
  logic                  out_vis_r, out_last_r;

  logic out_en, in_acc, is_load, emit;

  assign out_en  = !out_valid_r || out_ch.ready;
  assign in_acc  = in_ch.valid && out_en;
  assign is_load = (lrg_pkg::command_t'(in_ch.command) == lrg_pkg::CMD_LOAD);
  assign emit    = in_acc && !is_load && active_r;

  // load setup
  logic signed [C-1:0]   sa0, sb0, sa1, sb1, oa0, ob0, oa1, ob1;
  logic signed [D_W-1:0] dx, dy, dmaj, dmin;
  logic [D_W-1:0]        adx, ady;
  logic                  ld_steep;

  always_comb begin
    dx       = D_W'(in_ch.x_end) - D_W'(in_ch.x_start);
    dy       = D_W'(in_ch.y_end) - D_W'(in_ch.y_start);
    adx      = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
    ady      = dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
    ld_steep = adx < ady;
    sa0 = ld_steep ? in_ch.y_start : in_ch.x_start;
    sb0 = ld_steep ? in_ch.x_start : in_ch.y_start;
    sa1 = ld_steep ? in_ch.y_end   : in_ch.x_end;
    sb1 = ld_steep ? in_ch.x_end   : in_ch.y_end;
    // order along the major axis
    if (sa1 < sa0) begin
      oa0 = sa1; ob0 = sb1; oa1 = sa0; ob1 = sb0;
    end else begin
      oa0 = sa0; ob0 = sb0; oa1 = sa1; ob1 = sb1;
    end
    dmaj = D_W'(oa1) - D_W'(oa0);
    dmin = D_W'(ob1) - D_W'(ob0);
  end

  // step: current pixel, its address and the error update
  logic signed [C-1:0]   px, py, major_inc;
  logic [C-1:0]          px_u, py_u;
  logic                  vis, last;
  logic [PROD_W-1:0]     row_off;
  logic [A_W-1:0]        addr;
  logic signed [E_W-1:0] e_add;
  logic                  e_step;

  always_comb begin
    px        = steep_r ? minor_pos_r : major_pos_r;
    py        = steep_r ? major_pos_r : minor_pos_r;
    px_u      = px;
    py_u      = py;
    vis       = !px[C-1] && !py[C-1] && (CMP_W'(px_u) < CMP_W'(width_r)) &&
                (CMP_W'(py_u) < CMP_W'(height_r));
    // address only for on-screen pixels
    row_off   = PROD_W'(py_u) * PROD_W'(pitch_r);
    addr      = vis ? A_W'(row_off) + A_W'(px_u) : '0;
    major_inc = major_pos_r + C'(1);
    last      = (major_inc == major_end_r);
    e_add     = error_r + $signed({2'b00, minor_delta_r} << 1);
    e_step    = e_add >= $signed({2'b00, major_delta_r});
  end

  always_comb begin
    active_nxt      = active_r;
    steep_nxt       = steep_r;
    major_pos_nxt   = major_pos_r;
    major_end_nxt   = major_end_r;
    minor_pos_nxt   = minor_pos_r;
    minor_dir_nxt   = minor_dir_r;
    major_delta_nxt = major_delta_r;
    minor_delta_nxt = minor_delta_r;
    error_nxt       = error_r;
    if (in_acc && is_load) begin
      active_nxt      = (oa1 != oa0);
      steep_nxt       = ld_steep;
      major_pos_nxt   = oa0;
      major_end_nxt   = oa1;
      minor_pos_nxt   = ob0;
      minor_dir_nxt   = !(ob1 > ob0);
      major_delta_nxt = dmaj;
      minor_delta_nxt = dmin[D_W-1] ? D_W'(-dmin) : D_W'(dmin);
      error_nxt       = '0;
    end else if (emit) begin
      major_pos_nxt = major_inc;
      active_nxt    = !last;
      if (e_step) begin
        minor_pos_nxt = minor_dir_r ? minor_pos_r - C'(1) : minor_pos_r + C'(1);
        error_nxt     = e_add - $signed({2'b00, major_delta_r} << 1);
      end else begin
        error_nxt     = e_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= 1'b0;
      steep_r       <= 1'b0;
      major_pos_r   <= '0;
      major_end_r   <= '0;
      minor_pos_r   <= '0;
      minor_dir_r   <= 1'b0;
      major_delta_r <= '0;
      minor_delta_r <= '0;
      error_r       <= '0;
    end else begin
      active_r      <= active_nxt;
      steep_r       <= steep_nxt;
      major_pos_r   <= major_pos_nxt;
      major_end_r   <= major_end_nxt;
      minor_pos_r   <= minor_pos_nxt;
      minor_dir_r   <= minor_dir_nxt;
      major_delta_r <= major_delta_nxt;
      minor_delta_r <= minor_delta_nxt;
      error_r       <= error_nxt;
    end
  end

  assign out_valid_nxt = out_en ? emit : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x_r    <= px;
      out_y_r    <= py;
      out_vis_r  <= vis;
      out_last_r <= last;
      out_addr_r <= addr;
    end
  end

  assign in_ch.ready          = out_en;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.pixel_x       = out_x_r;
  assign out_ch.pixel_y       = out_y_r;
  assign out_ch.pixel_address = out_addr_r;
  assign out_ch.visible       = out_vis_r;
  assign out_ch.last_pixel    = out_last_r;

  `LRG_ASSERT_NOW(a_active_order, clk, rst_n, active_r, major_pos_r < major_end_r,
                  "active line has walked past its end")
  `LRG_ASSERT_NOW(a_delta_order, clk, rst_n, active_r, minor_delta_r <= major_delta_r,
                  "minor delta exceeds major delta")
  `LRG_ASSERT_NEXT(a_step_issue, clk, rst_n, emit, out_valid_r,
                   "accepted step on active line lost its pixel")
  `LRG_ASSERT_NEXT(a_load_clear, clk, rst_n, in_acc && is_load, error_r == '0,
                   "load did not clear the error term")
  `LRG_ASSERT_NOW(a_hidden_addr, clk, rst_n, out_valid_r && !out_vis_r, out_addr_r == '0,
                  "off-screen pixel carries an address")

endmodule
